/* hdl/haag_pkg.sv */
// Shared types and constants for the hammer access address generator.
// No dependencies; imported by the top level, front and back ends, job queue and remainder unit.
package haag_pkg;

  localparam int DEF_OFFSET_BITS = 32;
  localparam int DEF_JOBQ_DEPTH  = 2;

  // LCG constants
  localparam logic [31:0] LCG_MUL  = 32'd1103515245;
  localparam logic [31:0] LCG_ADD  = 32'd12345;
  localparam logic [31:0] LCG_MASK = 32'h7FFF_FFFF;

  // clears the low three bits (8-byte alignment)
  localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFF8;

  // remainder unit: dividend is left aligned in DVD_W bits
  localparam int DVD_W = 64;
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] NB_OP     = 7'd48;
  localparam logic [CNT_W-1:0] NB_STRIDE = 7'd32;
  localparam logic [CNT_W-1:0] NB_PROD   = 7'd64;
  localparam logic [CNT_W-1:0] NB_PIDX   = 7'd48;
  localparam logic [CNT_W-1:0] NB_LCG    = 7'd31;

  typedef enum logic [1:0] {
    MODE_SEQ    = 2'd0,
    MODE_RAND   = 2'd1,
    MODE_STRIDE = 2'd2,
    MODE_VICTIM = 2'd3
  } access_mode_e;

  typedef enum logic [2:0] {
    CFG_ACCESS_MODE     = 3'd0,
    CFG_STRIDE_DISTANCE = 3'd1,
    CFG_PAT_LEN         = 3'd2,
    CFG_REP_COUNT       = 3'd3,
    CFG_WINDOW_LIMIT    = 3'd4,
    CFG_WRITE_ENABLE    = 3'd5,
    CFG_FLUSH_LINES     = 3'd6,
    CFG_RAND_SEED       = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    JOB_SEQ,
    JOB_RAND,
    JOB_STRIDE
  } job_kind_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_A_GO,
    BK_A_WAIT,
    BK_B_GO,
    BK_B_WAIT,
    BK_MUL,
    BK_P_GO,
    BK_P_WAIT,
    BK_OUT
  } bk_state_e;

  typedef struct packed {
    access_mode_e access_mode;
    logic [31:0]  stride_distance;
    logic [15:0]  pat_len;
    logic [31:0]  rep_count;
    logic [31:0]  window_limit;
    logic         write_enable;
    logic         flush_lines;
    logic [31:0]  rand_seed;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    access_mode:     MODE_SEQ,
    stride_distance: 32'd8192,
    pat_len:         16'd4,
    rep_count:       32'd2000000,
    window_limit:    32'd32768,
    write_enable:    1'b1,
    flush_lines:     1'b1,
    rand_seed:       32'd1
  };

  // one access handed from front to back
  typedef struct packed {
    job_kind_e   kind;
    logic [47:0] opnd;        // op count, pattern index or LCG value
    logic        is_write;
    logic [32:0] write_value;
    logic        flush_first;
    logic        last_access;
  } job_t;

  typedef struct packed {
    logic [31:0] byte_offset;
    logic        is_write;
    logic [32:0] write_value;
    logic        flush_first;
    logic        last_access;
  } res_t;

endpackage

/* hdl/hammer_access_address_generator_top.sv */
// Top level of the hammer access address generator: configuration registers,
// front end, job queue and back end. Depends on haag_pkg, haag_front, haag_jobq and haag_back.
//
// Usage:
//   Tick words enter through push_i/full_o; restart_i=1 clears the pattern
//   counters and reloads the LCG from rand_seed before generating. Each tick
//   gives zero or one access word, read through empty_o/pop_i: the oldest
//   word sits on the result ports while empty_o is low.
//   Configuration is written through cfg_valid_i/cfg_ready_o (ready is
//   always high), cfg_index_i picks the register. The user must write it only
//   while idle; the block itself does not enforce this.
// Timing:
//   The front end takes one tick per cycle as long as the job queue has room.
//   The back end's bit-serial remainder unit (one dividend bit per cycle)
//   sets the cost of an access: one 31-bit remainder in random mode, one
//   multiply and a 48-bit remainder in sequential/victim mode, and three
//   remainders of 48, 32 and 64 bits plus one multiply in stride mode.
// Reset and stalls:
//   Reset loads the register defaults, clears counters and queues; no
//   clearing pass is needed. When pop_i stays low, one finished word waits
//   in the output register, the back end holds its next word, the job queue
//   fills and then full_o rises.
module hammer_access_address_generator_top import haag_pkg::*; #(
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  parameter int JOBQ_DEPTH  = DEF_JOBQ_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // tick words
  input  logic        push_i,
  output logic        full_o,
  input  logic        restart_i,
  // access words
  output logic        empty_o,
  input  logic        pop_i,
  output logic [31:0] byte_offset_o,
  output logic        is_write_o,
  output logic [32:0] write_value_o,
  output logic        flush_first_o,
  output logic        last_access_o
);

  cfg_t cfg_q;
  logic jq_push, jq_full, jq_empty, jq_pop;
  job_t jq_in, jq_out;
  res_t res;

  assign cfg_ready_o = 1'b1;

  // register file; narrow registers keep only their low bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ACCESS_MODE:     cfg_q.access_mode     <= access_mode_e'(cfg_data_i[1:0]);
        CFG_STRIDE_DISTANCE: cfg_q.stride_distance <= cfg_data_i;
        CFG_PAT_LEN:         cfg_q.pat_len         <= cfg_data_i[15:0];
        CFG_REP_COUNT:       cfg_q.rep_count       <= cfg_data_i;
        CFG_WINDOW_LIMIT:    cfg_q.window_limit    <= cfg_data_i;
        CFG_WRITE_ENABLE:    cfg_q.write_enable    <= cfg_data_i[0];
        CFG_FLUSH_LINES:     cfg_q.flush_lines     <= cfg_data_i[0];
        CFG_RAND_SEED:       cfg_q.rand_seed       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  haag_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push_i    (push_i),
    .restart_i (restart_i),
    .q_full_i  (jq_full),
    .jq_push_o (jq_push),
    .job_o     (jq_in)
  );

  haag_jobq #(
    .DEPTH (JOBQ_DEPTH)
  ) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (jq_push),
    .data_i  (jq_in),
    .full_o  (jq_full),
    .pop_i   (jq_pop),
    .empty_o (jq_empty),
    .data_o  (jq_out)
  );

  haag_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (!jq_empty),
    .job_i       (jq_out),
    .job_pop_o   (jq_pop),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .res_o       (res)
  );

  assign full_o        = jq_full;
  assign byte_offset_o = res.byte_offset;
  assign is_write_o    = res.is_write;
  assign write_value_o = res.write_value;
  assign flush_first_o = res.flush_first;
  assign last_access_o = res.last_access;

endmodule

/* hdl/haag_jobq.sv */
// Small flip-flop queue of access jobs between front and back.
// Depends on haag_pkg (job_t).
module haag_jobq import haag_pkg::*; #(
  parameter int DEPTH = DEF_JOBQ_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  job_t mem_q [DEPTH];
  logic [IdxW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [IdxW-1:0] next_ptr(input logic [IdxW-1:0] p);
    next_ptr = (p == IdxW'(DEPTH - 1)) ? '0 : p + IdxW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

/* hdl/haag_front.sv */
// Front end: takes tick words, keeps the pattern counters and LCG,
// and classifies each access into a job. Depends on haag_pkg.
module haag_front import haag_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic push_i,
  input  logic restart_i,
  input  logic q_full_i,
  output logic jq_push_o,
  output job_t job_o
);

  logic [31:0] rep_q, rep_d, rep_s, ri2;
  logic [15:0] pat_q, pat_d, pat_s, pi2, pn;
  logic [47:0] op_q, op_d, op_s;
  logic [30:0] lcg_q, lcg_d, lcg_s, lcg_n;
  logic        fin_q, fin_d, fin_s;
  logic        accept, gen, roll;
  logic [31:0] lcg_prod;
  job_kind_e   kind;

  assign accept = push_i && !q_full_i;

  always_comb begin
    case (cfg_i.access_mode)
      MODE_RAND:   kind = JOB_RAND;
      MODE_STRIDE: kind = JOB_STRIDE;
      default:     kind = JOB_SEQ;
    endcase
  end

  always_comb begin
    // restart clears before anything else
    rep_s = restart_i ? '0 : rep_q;
    pat_s = restart_i ? '0 : pat_q;
    op_s  = restart_i ? '0 : op_q;
    lcg_s = restart_i ? 31'(cfg_i.rand_seed & LCG_MASK) : lcg_q;
    fin_s = restart_i ? 1'b0 : fin_q;

    lcg_prod = LCG_MUL * {1'b0, lcg_s} + LCG_ADD;
    lcg_n    = 31'(lcg_prod & LCG_MASK);

    // pattern length may have dropped below the index: roll over first
    roll = (pat_s >= cfg_i.pat_len);
    pi2  = roll ? '0 : pat_s;
    ri2  = (roll && (rep_s < cfg_i.rep_count)) ? rep_s + 32'd1 : rep_s;
    pn   = pi2 + 16'd1;

    rep_d = rep_s;
    pat_d = pat_s;
    op_d  = op_s;
    lcg_d = lcg_s;
    fin_d = fin_s;
    gen   = 1'b0;

    if (!fin_s && (cfg_i.pat_len != '0)) begin
      rep_d = ri2;
      pat_d = pi2;
      if (ri2 >= cfg_i.rep_count) begin
        fin_d = 1'b1;
      end else begin
        gen  = 1'b1;
        op_d = op_s + 48'd1;
        if (kind == JOB_RAND) lcg_d = lcg_n;
        if (pn >= cfg_i.pat_len) begin
          pat_d = '0;
          rep_d = ri2 + 32'd1;
          fin_d = ((ri2 + 32'd1) >= cfg_i.rep_count);
        end else begin
          pat_d = pn;
        end
      end
    end

    job_o.kind = kind;
    case (kind)
      JOB_RAND:   job_o.opnd = {17'd0, lcg_n};
      JOB_STRIDE: job_o.opnd = op_s;
      default:    job_o.opnd = {32'd0, pi2};
    endcase
    job_o.is_write    = cfg_i.write_enable;
    job_o.write_value = cfg_i.write_enable ? ({1'b0, ri2} + {17'd0, pi2}) : '0;
    job_o.flush_first = cfg_i.flush_lines;
    job_o.last_access = (ri2 == cfg_i.rep_count - 32'd1) &&
                        (pi2 == cfg_i.pat_len - 16'd1);
  end

  assign jq_push_o = accept && gen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q <= '0;
      pat_q <= '0;
      op_q  <= '0;
      lcg_q <= 31'(CFG_RESET.rand_seed & LCG_MASK);
      fin_q <= 1'b0;
    end else if (accept) begin
      rep_q <= rep_d;
      pat_q <= pat_d;
      op_q  <= op_d;
      lcg_q <= lcg_d;
      fin_q <= fin_d;
    end
  end

endmodule

/* hdl/haag_rem.sv */
// Bit-serial remainder unit: one dividend bit per cycle, 33-bit modulus.
// Depends on haag_pkg (DVD_W, CNT_W).
module haag_rem import haag_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,  // left aligned
  input  logic [CNT_W-1:0] nbits_i,
  input  logic [32:0]      modulus_i,
  output logic             busy_o,
  output logic [31:0]      rem_o
);

  logic [CNT_W-1:0] cnt_q;
  logic [31:0]      rem_q, rem_d;
  logic [DVD_W-1:0] dvd_q;
  logic [32:0]      trial, diff;

  assign busy_o = (cnt_q != '0);
  assign rem_o  = rem_q;

  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - modulus_i;
    rem_d = (trial >= modulus_i) ? diff[31:0] : trial[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= nbits_i;
    end else if (busy_o) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
    end else if (busy_o) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
    end
  end

endmodule

/* hdl/haag_back.sv */
// Back end: computes the byte offset of each job with one multiplier and
// the remainder unit, and holds the result word. Depends on haag_pkg, haag_rem.
module haag_back import haag_pkg::*; #(
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic job_pop_o,
  output logic empty_o,
  input  logic pop_i,
  output res_t res_o
);

  localparam int          MaskW    = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
  localparam logic [63:0] OffMaskW = (64'd1 << MaskW) - 64'd1;
  localparam logic [31:0] OffMask  = OffMaskW[31:0];

  bk_state_e state_q, state_d;
  job_t        job_q;
  logic [31:0] a_mod_q;
  logic [63:0] prod_q, prod_d;
  res_t        res_q;
  logic        out_valid_q;

  logic             rem_start, rem_busy;
  logic [DVD_W-1:0] rem_dvd;
  logic [CNT_W-1:0] rem_nbits;
  logic [31:0]      rem_res;
  logic [32:0]      modulus;
  logic             a_load, prod_load, out_load;
  logic [31:0]      mul_a, mul_b, off_raw;

  assign modulus = {1'b0, cfg_i.window_limit} + 33'd1;

  haag_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dvd),
    .nbits_i    (rem_nbits),
    .modulus_i  (modulus),
    .busy_o     (rem_busy),
    .rem_o      (rem_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          case (job_i.kind)
            JOB_STRIDE: state_d = BK_A_GO;
            JOB_SEQ:    state_d = BK_MUL;
            default:    state_d = BK_P_GO;
          endcase
        end
      end
      BK_A_GO:   state_d = BK_A_WAIT;
      BK_A_WAIT: if (!rem_busy) state_d = BK_B_GO;
      BK_B_GO:   state_d = BK_B_WAIT;
      BK_B_WAIT: if (!rem_busy) state_d = BK_MUL;
      BK_MUL:    state_d = BK_P_GO;
      BK_P_GO:   state_d = BK_P_WAIT;
      BK_P_WAIT: if (!rem_busy) state_d = BK_OUT;
      BK_OUT:    if (!out_valid_q || pop_i) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_pop_o = 1'b0;
    rem_start = 1'b0;
    rem_dvd   = '0;
    rem_nbits = '0;
    a_load    = 1'b0;
    prod_load = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      BK_IDLE: job_pop_o = job_valid_i;
      BK_A_GO: begin
        rem_start = 1'b1;
        rem_dvd   = {job_q.opnd, 16'd0};
        rem_nbits = NB_OP;
      end
      BK_B_GO: begin
        rem_start = 1'b1;
        a_load    = 1'b1;
        rem_dvd   = {cfg_i.stride_distance, 32'd0};
        rem_nbits = NB_STRIDE;
      end
      BK_MUL: prod_load = 1'b1;
      BK_P_GO: begin
        rem_start = 1'b1;
        case (job_q.kind)
          JOB_STRIDE: begin
            rem_dvd   = prod_q;
            rem_nbits = NB_PROD;
          end
          JOB_SEQ: begin
            rem_dvd   = {prod_q[47:0], 16'd0};
            rem_nbits = NB_PIDX;
          end
          default: begin
            rem_dvd   = {job_q.opnd[30:0], 33'd0};
            rem_nbits = NB_LCG;
          end
        endcase
      end
      BK_OUT: out_load = !out_valid_q || pop_i;
      default: ;
    endcase
  end

  // stride: (op mod m) * (stride mod m); sequential: index * stride
  always_comb begin
    if (job_q.kind == JOB_STRIDE) begin
      mul_a = a_mod_q;
      mul_b = rem_res;
    end else begin
      mul_a = {16'd0, job_q.opnd[15:0]};
      mul_b = cfg_i.stride_distance;
    end
    prod_d  = {32'd0, mul_a} * {32'd0, mul_b};
    off_raw = (job_q.kind == JOB_RAND) ? (rem_res & ALIGN_MASK) : rem_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)                   out_valid_q <= 1'b1;
      else if (pop_i && out_valid_q)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) job_q   <= job_i;
    if (a_load)    a_mod_q <= rem_res;
    if (prod_load) prod_q  <= prod_d;
    if (out_load) begin
      res_q.byte_offset <= off_raw & OffMask;
      res_q.is_write    <= job_q.is_write;
      res_q.write_value <= job_q.write_value;
      res_q.flush_first <= job_q.flush_first;
      res_q.last_access <= job_q.last_access;
    end
  end

  assign empty_o = !out_valid_q;
  assign res_o   = res_q;

endmodule

/* hdl/haag_checker.sv */
// Port-level assertions for the hammer access address generator top level,
// and the bind that attaches them. Depends on hammer_access_address_generator_top.
module haag_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push_i,
  input logic        full_i,
  input logic        pop_i,
  input logic        empty_i,
  input logic [31:0] byte_offset_i,
  input logic        is_write_i,
  input logic [32:0] write_value_i
);

  // no word is shown while reset is held
  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |-> empty_i)
    else $error("result shown during reset");

  // a waiting word holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !pop_i) |=> (!empty_i && $stable(byte_offset_i) && $stable(write_value_i)))
    else $error("waiting word changed");

  // reads carry zero data
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !is_write_i) |-> (write_value_i == 33'd0))
    else $error("read access with nonzero data");

  // the job queue only fills on a push
  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_i) |-> $past(push_i))
    else $error("full rose without push");

  // the output register only drains on a pop
  a_empty_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty_i) |-> $past(pop_i))
    else $error("result dropped without pop");

endmodule

bind hammer_access_address_generator_top haag_checker u_haag_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .push_i        (push_i),
  .full_i        (full_o),
  .pop_i         (pop_i),
  .empty_i       (empty_o),
  .byte_offset_i (byte_offset_o),
  .is_write_i    (is_write_o),
  .write_value_i (write_value_o)
);

/* tb/sv/tb.sv */
// Self-checking testbench for hammer_access_address_generator_top.
// Needs haag_pkg and the block's RTL; tick words go in, access words are checked
// against a predictor built in this file.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import haag_pkg::*;

  localparam int          SETTLE_CYCLES = 200;      // slowest access (stride) plus margin
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          SEGMENTS      = 16;
  localparam int          SEG_TICKS     = 28;
  localparam logic [31:0] GEN_MUL       = 32'd1103515245;
  localparam logic [31:0] GEN_INC       = 32'd12345;

  // DUT ports
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        push_i;
  logic        full_o;
  logic        restart_i;
  logic        empty_o;
  logic        pop_i;
  logic [31:0] byte_offset_o;
  logic        is_write_o;
  logic [32:0] write_value_o;
  logic        flush_first_o;
  logic        last_access_o;

  // predictor state: register copy and generator counters
  cfg_t        gen_cfg;
  logic [31:0] gen_rep;
  logic [15:0] gen_pat;
  logic [47:0] gen_ops;
  logic [30:0] gen_lcg;
  logic        gen_done;

  logic        tick_backlog[$];    // restart flags waiting to be pushed
  res_t        access_backlog[$];  // accesses owed by the block, oldest first
  res_t        got_access;

  int          errors;
  int          cycles;
  int          ticks_queued;
  int          ticks_taken;
  int          accesses_checked;
  int          full_cycles;
  int          cfg_writes;
  int          mode_count[4];
  int          tx_idle_pct;
  int          rx_stall_pct;
  logic        rx_hold;
  logic        word_taken;

  hammer_access_address_generator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push_i        (push_i),
    .full_o        (full_o),
    .restart_i     (restart_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .byte_offset_o (byte_offset_o),
    .is_write_o    (is_write_o),
    .write_value_o (write_value_o),
    .flush_first_o (flush_first_o),
    .last_access_o (last_access_o)
  );

  always #10 clk_i = ~clk_i;

  // Register write as the block sees it; widths trimmed to the field.
  function automatic void gen_cfg_write(input cfg_idx_e idx, input logic [31:0] data);
    case (idx)
      CFG_ACCESS_MODE:     gen_cfg.access_mode = access_mode_e'(data[1:0]);
      CFG_STRIDE_DISTANCE: gen_cfg.stride_distance = data;
      CFG_PAT_LEN:         gen_cfg.pat_len = data[15:0];
      CFG_REP_COUNT:       gen_cfg.rep_count = data;
      CFG_WINDOW_LIMIT:    gen_cfg.window_limit = data;
      CFG_WRITE_ENABLE:    gen_cfg.write_enable = data[0];
      CFG_FLUSH_LINES:     gen_cfg.flush_lines = data[0];
      CFG_RAND_SEED:       gen_cfg.rand_seed = data;
      default: ;
    endcase
  endfunction

  // One accepted tick: advance the generator and queue the access it owes, if any.
  function automatic void step_generator(input logic restart);
    res_t        acc;
    logic [63:0] modulus;
    logic [63:0] offset;
    logic [31:0] lcg_next;
    if (restart) begin
      gen_rep  = '0;
      gen_pat  = '0;
      gen_ops  = '0;
      gen_lcg  = gen_cfg.rand_seed[30:0];
      gen_done = 1'b0;
    end
    if (gen_done || gen_cfg.pat_len == 16'd0) return;
    // pattern length may have been lowered under the running index
    if (gen_pat >= gen_cfg.pat_len) begin
      gen_pat = '0;
      if (gen_rep < gen_cfg.rep_count) gen_rep = gen_rep + 32'd1;
    end
    if (gen_rep >= gen_cfg.rep_count) begin
      gen_done = 1'b1;
      return;
    end

    // window_limit + 1 can be 2^32, so work in 64 bits
    modulus = {32'd0, gen_cfg.window_limit} + 64'd1;
    case (gen_cfg.access_mode)
      MODE_RAND: begin
        lcg_next = GEN_MUL * {1'b0, gen_lcg} + GEN_INC;
        gen_lcg  = lcg_next[30:0];
        offset   = {33'd0, gen_lcg} % modulus;
        offset   = offset & ~64'd7;
      end
      MODE_STRIDE: begin
        offset = (({16'd0, gen_ops} % modulus) *
                  ({32'd0, gen_cfg.stride_distance} % modulus)) % modulus;
      end
      default: begin
        offset = ({48'd0, gen_pat} * {32'd0, gen_cfg.stride_distance}) % modulus;
      end
    endcase

    acc.byte_offset = offset[31:0];
    acc.is_write    = gen_cfg.write_enable;
    acc.write_value = gen_cfg.write_enable ? {1'b0, gen_rep} + {17'd0, gen_pat} : 33'd0;
    acc.flush_first = gen_cfg.flush_lines;
    acc.last_access = (gen_rep == gen_cfg.rep_count - 32'd1) &&
                      (gen_pat == gen_cfg.pat_len - 16'd1);
    access_backlog.push_back(acc);
    mode_count[gen_cfg.access_mode]++;

    gen_ops = gen_ops + 48'd1;
    gen_pat = gen_pat + 16'd1;
    if (gen_pat >= gen_cfg.pat_len) begin
      gen_pat = '0;
      gen_rep = gen_rep + 32'd1;
      if (gen_rep >= gen_cfg.rep_count) gen_done = 1'b1;
    end
  endfunction

  function automatic void check_field(input string what, input logic [32:0] want,
                                      input logic [32:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
    end
  endfunction

  // Driver: tick words and pop, both changed on the falling edge.
  // A raised push stays up until its word is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!push_i || word_taken) begin
        if (tick_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          push_i    <= 1'b1;
          restart_i <= tick_backlog.pop_front();
        end else begin
          push_i    <= 1'b0;
          restart_i <= 1'($urandom_range(1));
        end
      end
      pop_i <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Monitor: samples both handshakes on the rising edge, predicts and checks.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles++;
      word_taken = push_i && !full_o;
      if (word_taken) begin
        ticks_taken++;
        step_generator(restart_i);
      end
      if (full_o) full_cycles++;
      if (pop_i && !empty_o) begin
        if (access_backlog.size() == 0) begin
          errors++;
          $display("%0t: access word with none expected, offset %h value %h",
                   $time, byte_offset_o, write_value_o);
        end else begin
          got_access = access_backlog.pop_front();
          accesses_checked++;
          check_field("byte_offset", {1'b0, got_access.byte_offset}, {1'b0, byte_offset_o});
          check_field("is_write", {32'd0, got_access.is_write}, {32'd0, is_write_o});
          check_field("write_value", got_access.write_value, write_value_o);
          check_field("flush_first", {32'd0, got_access.flush_first}, {32'd0, flush_first_o});
          check_field("last_access", {32'd0, got_access.last_access}, {32'd0, last_access_o});
        end
      end
      if (cycles >= CYCLE_LIMIT) begin
        $display("%0t: timeout, %0d accesses still owed", $time, access_backlog.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic add_tick(input logic restart);
    tick_backlog.push_back(restart);
    ticks_queued++;
  endtask

  // Wait until every tick is taken and every access seen, then let the
  // back end settle so no tick without an access is still in flight.
  task automatic drain();
    do @(negedge clk_i);
    while (ticks_taken != ticks_queued || access_backlog.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    gen_cfg_write(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // 32-bit register value: mostly the supplied typical value or random,
  // now and then an extreme.
  function automatic logic [31:0] pick_wide(input logic [31:0] typical);
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom();
      default: return typical;
    endcase
  endfunction

  function automatic logic [31:0] pick_length();
    case ($urandom_range(19))
      0:       return 32'd0;
      1:       return 32'd65535;
      2, 3, 4: return $urandom_range(7, 40);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  // One random segment: reprogram a random subset of the registers, then a
  // run of ticks that usually opens with a restart.
  task automatic random_segment(input int n_ticks);
    if ($urandom_range(99) < 70) write_reg(CFG_ACCESS_MODE, $urandom_range(3));
    if ($urandom_range(99) < 70) write_reg(CFG_STRIDE_DISTANCE,
                                           pick_wide(32'(64 * $urandom_range(255))));
    if ($urandom_range(99) < 70) write_reg(CFG_PAT_LEN, pick_length());
    if ($urandom_range(99) < 70) write_reg(CFG_REP_COUNT, pick_wide($urandom_range(1, 5)));
    if ($urandom_range(99) < 70) write_reg(CFG_WINDOW_LIMIT,
                                           pick_wide($urandom_range(4095)));
    if ($urandom_range(99) < 50) write_reg(CFG_WRITE_ENABLE, $urandom_range(1));
    if ($urandom_range(99) < 50) write_reg(CFG_FLUSH_LINES, $urandom_range(1));
    if ($urandom_range(99) < 50) write_reg(CFG_RAND_SEED, $urandom());
    add_tick($urandom_range(99) < 60);
    repeat (n_ticks - 1) add_tick($urandom_range(99) < 8);
    drain();
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_ACCESS_MODE;
    cfg_data_i   = '0;
    push_i       = 1'b0;
    restart_i    = 1'b0;
    pop_i        = 1'b0;
    rx_hold      = 1'b0;
    word_taken   = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    // register values right after reset
    gen_cfg = '{access_mode: MODE_SEQ, stride_distance: 32'd8192, pat_len: 16'd4,
                rep_count: 32'd2000000, window_limit: 32'd32768, write_enable: 1'b1,
                flush_lines: 1'b1, rand_seed: 32'd1};
    gen_rep  = '0;
    gen_pat  = '0;
    gen_ops  = '0;
    gen_lcg  = 31'd1;
    gen_done = 1'b0;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed part, no idling ---
    // defaults straight out of reset, then a restart mid-pattern
    add_tick(1'b0);
    add_tick(1'b1);
    drain();
    // zero pattern length: ticks give nothing
    write_reg(CFG_PAT_LEN, 32'd0);
    add_tick(1'b1);
    add_tick(1'b0);
    drain();
    // two reps of two, widest window and stride, reads without flush;
    // the fifth tick finds the generator finished
    write_reg(CFG_PAT_LEN, 32'd2);
    write_reg(CFG_REP_COUNT, 32'd2);
    write_reg(CFG_WINDOW_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_STRIDE_DISTANCE, 32'hFFFF_FFFF);
    write_reg(CFG_WRITE_ENABLE, 32'd0);
    write_reg(CFG_FLUSH_LINES, 32'd0);
    add_tick(1'b1);
    repeat (4) add_tick(1'b0);
    drain();
    // zero repetitions
    write_reg(CFG_REP_COUNT, 32'd0);
    add_tick(1'b1);
    drain();
    // pattern length lowered under the running index rolls to the next rep
    write_reg(CFG_REP_COUNT, 32'hFFFF_FFFF);
    write_reg(CFG_PAT_LEN, 32'd6);
    write_reg(CFG_WRITE_ENABLE, 32'd1);
    write_reg(CFG_FLUSH_LINES, 32'd1);
    add_tick(1'b1);
    repeat (3) add_tick(1'b0);
    drain();
    write_reg(CFG_PAT_LEN, 32'd2);
    add_tick(1'b0);
    drain();
    // random mode, seed with its top bit set, then a window of zero
    write_reg(CFG_ACCESS_MODE, 32'(MODE_RAND));
    write_reg(CFG_RAND_SEED, 32'hFFFF_FFFF);
    add_tick(1'b1);
    add_tick(1'b0);
    drain();
    write_reg(CFG_WINDOW_LIMIT, 32'd0);
    add_tick(1'b0);
    drain();
    // mode switch without restart: LCG must hold while sequential runs
    write_reg(CFG_WINDOW_LIMIT, 32'd1000);
    write_reg(CFG_ACCESS_MODE, 32'(MODE_SEQ));
    add_tick(1'b0);
    drain();
    write_reg(CFG_ACCESS_MODE, 32'(MODE_RAND));
    add_tick(1'b0);
    drain();
    // stride with the widest distance, then zero distance
    write_reg(CFG_ACCESS_MODE, 32'(MODE_STRIDE));
    write_reg(CFG_WINDOW_LIMIT, 32'hFFFF_FFFE);
    add_tick(1'b0);
    drain();
    write_reg(CFG_STRIDE_DISTANCE, 32'd0);
    add_tick(1'b0);
    drain();
    // zero seed, then victim mode
    write_reg(CFG_ACCESS_MODE, 32'(MODE_RAND));
    write_reg(CFG_RAND_SEED, 32'd0);
    write_reg(CFG_PAT_LEN, 32'd65535);
    add_tick(1'b1);
    drain();
    write_reg(CFG_ACCESS_MODE, 32'(MODE_VICTIM));
    write_reg(CFG_STRIDE_DISTANCE, 32'd4096);
    add_tick(1'b0);
    drain();
    // long receiver hold-off with a long pattern still running: every tick
    // owes an access, so the output register and job queue fill and full_o
    // holds the remaining ticks back
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    repeat (10) add_tick(1'b0);
    drain();

    // --- random part: four idling phases of four segments each ---
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 67; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 67; end
        default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
      endcase
      // long receiver hold-off while the sender keeps offering: the job
      // queue and output register fill and full_o must back-pressure
      if (seg == 9) begin
        fork
          begin
            rx_hold = 1'b1;
            repeat (400) @(posedge clk_i);
            rx_hold = 1'b0;
          end
        join_none
      end
      random_segment(SEG_TICKS);
    end

    $display("Run covered %0d ticks, %0d accesses (seq %0d, random %0d, stride %0d, victim %0d)",
             ticks_taken, accesses_checked, mode_count[MODE_SEQ], mode_count[MODE_RAND],
             mode_count[MODE_STRIDE], mode_count[MODE_VICTIM]);
    $display("%0d register writes; tick input held off by full_o for %0d cycles",
             cfg_writes, full_cycles);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* hammer_access_address_generator_top.f */
hdl/haag_pkg.sv
hdl/haag_jobq.sv
hdl/haag_front.sv
hdl/haag_rem.sv
hdl/haag_back.sv
hdl/hammer_access_address_generator_top.sv
hdl/haag_checker.sv
tb/sv/tb.sv
